// ===== sv/fhs_pkg.sv =====
// Shared types and constants for the fire heat simulation block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fhs_pkg;

  localparam int MAX_CELLS  = 64;
  localparam int SPARK_ZONE = 7;
  localparam int MIN_CELLS  = 3;

  localparam int ADDR_W  = $clog2(MAX_CELLS);
  localparam int CNT_W   = $clog2(MAX_CELLS + 1);
  localparam int HEAT_W  = 8;
  localparam int INDEX_W = 6;
  localparam int CELLS_W = 7;
  localparam int SEED_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;
  localparam int                LFSR_STEPS   = 8;

  localparam logic [CELLS_W-1:0] ACTIVE_CELLS_RESET    = 7'd60;
  localparam logic [HEAT_W-1:0]  COOLING_LOW_RESET     = 8'd20;
  localparam logic [HEAT_W-1:0]  COOLING_HIGH_RESET    = 8'd100;
  localparam logic [HEAT_W-1:0]  SPARKING_LOW_RESET    = 8'd50;
  localparam logic [HEAT_W-1:0]  SPARKING_HIGH_RESET   = 8'd200;
  localparam logic [HEAT_W-1:0]  SPARK_HEAT_LOW_RESET  = 8'd100;
  localparam logic [HEAT_W-1:0]  SPARK_HEAT_HIGH_RESET = 8'd255;
  localparam logic [SEED_W-1:0]  RANDOM_SEED_RESET     = 16'd44257;

  localparam int DIV_W      = 12;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int COOL_GAIN  = 10;
  localparam int BOUND_BIAS = 2;
  localparam int HEAT_MAX   = 255;

  localparam int DRIFT_FIRST = 2;
  localparam int DRIFT_RECIP = 683;
  localparam int DRIFT_SHIFT = 11;
  localparam int SPARK_SPAN  = 30;
  localparam int FORCE0_DROP = 20;
  localparam int FORCE1_DROP = 10;
  localparam int MAP_STEPS   = 3;

  typedef enum logic [2:0] {
    CFG_ACTIVE_CELLS,
    CFG_COOLING_LOW,
    CFG_COOLING_HIGH,
    CFG_SPARKING_LOW,
    CFG_SPARKING_HIGH,
    CFG_SPARK_HEAT_LOW,
    CFG_SPARK_HEAT_HIGH,
    CFG_RANDOM_SEED
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ALU_MAP,
    ALU_COOL,
    ALU_DRIFT,
    ALU_SCALE,
    ALU_AMT,
    ALU_SATADD
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [HEAT_W-1:0] a;
    logic [HEAT_W-1:0] b;
    logic [HEAT_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [HEAT_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_DIV,
    ST_BOUND,
    ST_COOL,
    ST_DRIFT,
    ST_SPARK,
    ST_SPARK_POS,
    ST_SPARK_AMT,
    ST_SPARK_ADD,
    ST_FORCE,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

endpackage

`default_nettype wire

// ===== sv/led_fire_heat_simulation.sv =====
// Fire heat simulation top level: configuration registers, sequencer, divider
// and output register. Uses fhs_pkg, fhs_heat_mem, fhs_rng and fhs_alu.
//
// Each input item is one frame tick carrying an audio level byte. The block
// maps the level into cooling, spark chance and spark heat, cools every
// active cell, lets heat drift upward, maybe adds a spark near the bottom,
// pins cells 0 and 1, then sends one result item per active cell, cell 0
// first, with last_cell set on the final one.
// Input items use in_valid/in_ready; in_ready is high only while the block
// is idle and out of reset. Result items leave through a single output
// register on out_valid/out_ready. Configuration is written through cfg_we,
// cfg_index and cfg_data; a seed write also reloads the random generator.
// The next item is taken only after the last result has been loaded into the
// output register. Frame throughput is set by the single write port of the
// heat store, walked once per pass, and by the read-out pass.
// A stalled receiver holds the read-out.
// Reset clears the heat store at once through per-cell valid bits.
`default_nettype none

module led_fire_heat_simulation import fhs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [INDEX_W-1:0]   cell_index,
  output logic [HEAT_W-1:0]    cell_heat,
  output logic                 last_cell,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CELLS_W-1:0] active_cells;
  logic [HEAT_W-1:0]  cooling_low;
  logic [HEAT_W-1:0]  cooling_high;
  logic [HEAT_W-1:0]  sparking_low;
  logic [HEAT_W-1:0]  sparking_high;
  logic [HEAT_W-1:0]  spark_heat_low;
  logic [HEAT_W-1:0]  spark_heat_high;

  state_t state;
  state_t state_next;

  logic [7:0]           level_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     n_last;
  logic [1:0]           step;
  logic [HEAT_W-1:0]    cooling_v;
  logic [HEAT_W-1:0]    sparking_v;
  logic [HEAT_W-1:0]    heat_v;
  logic [DIV_W-1:0]     div_q;
  logic [CNT_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W:0]       div_t;
  logic [CNT_W:0]       div_diff;
  logic                 div_ge;
  logic [CNT_W-1:0]     div_rem_next;
  logic [DIV_W-1:0]     bound_sum;
  logic [HEAT_W-1:0]    bound_r;
  logic [CNT_W-1:0]     rd_idx;
  logic                 rd_go;
  logic                 p_valid;
  logic [CNT_W-1:0]     p_idx;
  logic [HEAT_W-1:0]    y_r;
  logic [HEAT_W-1:0]    amt_r;
  logic                 spark_hit;
  logic                 out_load;

  mem_req_t          mem_req;
  logic [HEAT_W-1:0] rdata_a;
  logic [HEAT_W-1:0] rdata_b;
  alu_req_t          alu_req;
  logic [HEAT_W-1:0] alu_res;
  logic              rng_load;
  logic              rng_step;
  logic [HEAT_W-1:0] rng_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cells    <= ACTIVE_CELLS_RESET;
      cooling_low     <= COOLING_LOW_RESET;
      cooling_high    <= COOLING_HIGH_RESET;
      sparking_low    <= SPARKING_LOW_RESET;
      sparking_high   <= SPARKING_HIGH_RESET;
      spark_heat_low  <= SPARK_HEAT_LOW_RESET;
      spark_heat_high <= SPARK_HEAT_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ACTIVE_CELLS:    active_cells    <= cfg_data[CELLS_W-1:0];
        CFG_COOLING_LOW:     cooling_low     <= cfg_data[HEAT_W-1:0];
        CFG_COOLING_HIGH:    cooling_high    <= cfg_data[HEAT_W-1:0];
        CFG_SPARKING_LOW:    sparking_low    <= cfg_data[HEAT_W-1:0];
        CFG_SPARKING_HIGH:   sparking_high   <= cfg_data[HEAT_W-1:0];
        CFG_SPARK_HEAT_LOW:  spark_heat_low  <= cfg_data[HEAT_W-1:0];
        CFG_SPARK_HEAT_HIGH: spark_heat_high <= cfg_data[HEAT_W-1:0];
        CFG_RANDOM_SEED:     ;
        default:             ;
      endcase
    end
  end

  assign rng_load = cfg_we && (cfg_reg_t'(cfg_index) == CFG_RANDOM_SEED);

  assign n_clamp = (32'(active_cells) < MIN_CELLS) ? CNT_W'(MIN_CELLS) :
                   (32'(active_cells) > MAX_CELLS) ? CNT_W'(MAX_CELLS) :
                   CNT_W'(active_cells);
  assign n_last  = n_r - CNT_W'(1);

  assign div_t        = {div_rem, div_q[DIV_W-1]};
  assign div_diff     = div_t - {1'b0, n_r};
  assign div_ge       = div_t >= {1'b0, n_r};
  assign div_rem_next = div_ge ? div_diff[CNT_W-1:0] : div_t[CNT_W-1:0];
  assign bound_sum    = div_q + DIV_W'(BOUND_BIAS);

  assign spark_hit = 32'(y_r) < MAX_CELLS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    rng_step   = 1'b0;
    rd_go      = 1'b0;
    mem_req    = '0;
    alu_req    = '0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        alu_req.op = ALU_MAP;
        alu_req.a  = level_r;
        case (step)
          2'd0: begin
            alu_req.b = cooling_low;
            alu_req.c = cooling_high;
          end
          2'd1: begin
            alu_req.b = sparking_low;
            alu_req.c = sparking_high;
          end
          default: begin
            alu_req.b = spark_heat_low;
            alu_req.c = spark_heat_high;
          end
        endcase
        if (32'(step) == MAP_STEPS - 1) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (32'(div_cnt) == DIV_W - 1) begin
          state_next = ST_BOUND;
        end
      end
      ST_BOUND: state_next = ST_COOL;
      ST_COOL: begin
        rd_go           = rd_idx < n_r;
        mem_req.raddr_a = ADDR_W'(rd_idx);
        alu_req.op      = ALU_COOL;
        alu_req.a       = rng_byte;
        alu_req.b       = bound_r;
        alu_req.c       = rdata_a;
        if (p_valid) begin
          rng_step      = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.waddr = ADDR_W'(p_idx);
          mem_req.wdata = alu_res;
          if (p_idx == n_last) begin
            state_next = ST_DRIFT;
          end
        end
      end
      ST_DRIFT: begin
        rd_go           = rd_idx >= CNT_W'(DRIFT_FIRST);
        mem_req.raddr_a = ADDR_W'(rd_idx - CNT_W'(1));
        mem_req.raddr_b = ADDR_W'(rd_idx - CNT_W'(2));
        alu_req.op      = ALU_DRIFT;
        alu_req.a       = rdata_a;
        alu_req.b       = rdata_b;
        if (p_valid) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ADDR_W'(p_idx);
          mem_req.wdata = alu_res;
          if (p_idx == CNT_W'(DRIFT_FIRST)) begin
            state_next = ST_SPARK;
          end
        end
      end
      ST_SPARK: begin
        rng_step   = 1'b1;
        state_next = (rng_byte < sparking_v) ? ST_SPARK_POS : ST_FORCE;
      end
      ST_SPARK_POS: begin
        rng_step   = 1'b1;
        alu_req.op = ALU_SCALE;
        alu_req.a  = rng_byte;
        alu_req.b  = HEAT_W'(SPARK_ZONE);
        state_next = ST_SPARK_AMT;
      end
      ST_SPARK_AMT: begin
        rng_step        = 1'b1;
        alu_req.op      = ALU_AMT;
        alu_req.a       = rng_byte;
        alu_req.b       = heat_v;
        mem_req.raddr_a = ADDR_W'(y_r);
        state_next      = ST_SPARK_ADD;
      end
      ST_SPARK_ADD: begin
        alu_req.op    = ALU_SATADD;
        alu_req.a     = rdata_a;
        alu_req.b     = amt_r;
        mem_req.we    = spark_hit;
        mem_req.waddr = ADDR_W'(y_r);
        mem_req.wdata = alu_res;
        state_next    = ST_FORCE;
      end
      ST_FORCE: begin
        mem_req.we = 1'b1;
        if (step[0]) begin
          mem_req.waddr = ADDR_W'(1);
          mem_req.wdata = heat_v - HEAT_W'(FORCE1_DROP);
          state_next    = ST_OUT_RD;
        end else begin
          mem_req.waddr = ADDR_W'(0);
          mem_req.wdata = heat_v - HEAT_W'(FORCE0_DROP);
        end
      end
      ST_OUT_RD: begin
        mem_req.raddr_a = ADDR_W'(rd_idx);
        if (!out_valid || out_ready) begin
          state_next = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        out_load   = 1'b1;
        state_next = (rd_idx == n_last) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          p_valid <= 1'b0;
          if (in_valid) begin
            level_r <= level;
            n_r     <= n_clamp;
            step    <= '0;
          end
        end
        ST_MAP: begin
          case (step)
            2'd0:    cooling_v  <= alu_res;
            2'd1:    sparking_v <= alu_res;
            default: heat_v     <= alu_res;
          endcase
          step    <= step + 2'd1;
          div_q   <= DIV_W'(cooling_v) * DIV_W'(COOL_GAIN);
          div_rem <= '0;
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_rem <= div_rem_next;
          div_q   <= {div_q[DIV_W-2:0], div_ge};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        ST_BOUND: begin
          bound_r <= (bound_sum > DIV_W'(HEAT_MAX)) ? HEAT_W'(HEAT_MAX) : HEAT_W'(bound_sum);
          rd_idx  <= '0;
          p_valid <= 1'b0;
        end
        ST_COOL: begin
          p_valid <= rd_go;
          p_idx   <= rd_idx;
          if (rd_go) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (p_valid && (p_idx == n_last)) begin
            rd_idx  <= n_last;
            p_valid <= 1'b0;
          end
        end
        ST_DRIFT: begin
          p_valid <= rd_go;
          p_idx   <= rd_idx;
          if (rd_go) begin
            rd_idx <= rd_idx - CNT_W'(1);
          end
        end
        ST_SPARK: begin
          p_valid <= 1'b0;
          step    <= '0;
        end
        ST_SPARK_POS: y_r   <= alu_res;
        ST_SPARK_AMT: amt_r <= alu_res;
        ST_FORCE: begin
          step <= step + 2'd1;
          if (step[0]) begin
            rd_idx <= '0;
          end
        end
        ST_OUT_LD: rd_idx <= rd_idx + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_index <= INDEX_W'(rd_idx);
      cell_heat  <= rdata_a;
      last_cell  <= rd_idx == n_last;
    end
  end

  fhs_heat_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  fhs_rng u_rng (
    .clk  (clk),
    .rst  (rst),
    .load (rng_load),
    .seed (cfg_data[SEED_W-1:0]),
    .step (rng_step),
    .rnd  (rng_byte)
  );

  fhs_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // The output register must be free whenever a cell is loaded into it.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_LD) |-> !out_valid)
    else $error("output register overwritten while holding an item");

  a_pass_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COOL) || (state == ST_DRIFT)) && mem_req.we |->
      (CNT_W'(mem_req.waddr) < n_r))
    else $error("cell pass wrote beyond the active cells");

  a_drift_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRIFT) && p_valid |-> (p_idx >= CNT_W'(DRIFT_FIRST)))
    else $error("upward drift reached cell 0 or 1");

  a_cool_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COOL) |-> (rd_idx <= n_r))
    else $error("cooling read index ran past the cell count");

endmodule

`default_nettype wire

// ===== sv/fhs_heat_mem.sv =====
// Heat cell store: one write port, two registered read ports.
// Per-entry valid bits make every entry read as zero after reset; uses fhs_pkg.
`default_nettype none

module fhs_heat_mem import fhs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mem_req_t          req,
  output logic [HEAT_W-1:0] rdata_a,
  output logic [HEAT_W-1:0] rdata_b
);

  logic [HEAT_W-1:0]    mem [MAX_CELLS];
  logic [MAX_CELLS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= valid[req.raddr_a] ? mem[req.raddr_a] : '0;
    rdata_b <= valid[req.raddr_b] ? mem[req.raddr_b] : '0;
  end

endmodule

`default_nettype wire

// ===== sv/fhs_rng.sv =====
// Random byte source: 16-bit Galois LFSR advanced eight bits per byte.
// Loaded with the reset seed on reset and from the written data on a seed write; uses fhs_pkg.
`default_nettype none

module fhs_rng import fhs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [SEED_W-1:0] seed,
  input  logic              step,
  output logic [HEAT_W-1:0] rnd
);

  logic [SEED_W-1:0] state;
  logic [SEED_W-1:0] state_next;

  always_comb begin
    state_next = state;
    for (int i = 0; i < LFSR_STEPS; i++) begin
      state_next = state_next[0] ? ((state_next >> 1) ^ LFSR_TAPS) : (state_next >> 1);
    end
  end

  assign rnd = state_next[HEAT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RANDOM_SEED_RESET;
    end else if (load) begin
      state <= (seed == '0) ? SEED_W'(1) : seed;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fhs_alu.sv =====
// Shared arithmetic unit: one 10x10 multiplier followed by add, compare and clamp.
// Serves the level maps, cooling, upward drift and spark steps; uses fhs_pkg.
`default_nettype none

module fhs_alu import fhs_pkg::*; (
  input  alu_req_t          req,
  output logic [HEAT_W-1:0] res
);

  logic [9:0]        mul_a;
  logic [9:0]        mul_b;
  logic [19:0]       prod;
  logic [8:0]        diff;
  logic              diff_neg;
  logic [HEAT_W-1:0] mag;
  logic [16:0]       map_sum;
  logic [HEAT_W-1:0] map_q;
  logic [HEAT_W-1:0] scaled;
  logic [9:0]        drift_sum;
  logic [8:0]        sat_sum;

  assign diff      = {1'b0, req.c} - {1'b0, req.b};
  assign diff_neg  = diff[8];
  assign mag       = diff_neg ? 8'(-diff) : diff[7:0];
  assign drift_sum = 10'({req.a, 1'b0}) + 10'(req.b);
  assign sat_sum   = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    mul_a = 10'(req.a);
    mul_b = 10'(req.b);
    case (req.op)
      ALU_MAP:   mul_b = 10'(mag);
      ALU_DRIFT: begin
        mul_a = drift_sum;
        mul_b = 10'(DRIFT_RECIP);
      end
      ALU_AMT:   mul_b = 10'(SPARK_SPAN);
      default:   mul_b = 10'(req.b);
    endcase
  end

  assign prod = mul_a * mul_b;

  // Division by 255 of a product below 65536 without a divider.
  assign map_sum = 17'(prod[15:0]) + 17'(prod[15:8]) + 17'd1;
  assign map_q   = map_sum[15:8];
  assign scaled  = prod[15:8];

  always_comb begin
    case (req.op)
      ALU_MAP:    res = diff_neg ? (req.b - map_q) : (req.b + map_q);
      ALU_COOL:   res = (req.c > scaled) ? (req.c - scaled) : '0;
      ALU_DRIFT:  res = prod[DRIFT_SHIFT+HEAT_W-1:DRIFT_SHIFT];
      ALU_SCALE:  res = scaled;
      ALU_AMT:    res = req.b - 8'(SPARK_SPAN) + scaled;
      ALU_SATADD: res = sat_sum[8] ? 8'(HEAT_MAX) : sat_sum[7:0];
      default:    res = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sim/led_fire_heat_simulation_test.sv =====
// Self-checking testbench for led_fire_heat_simulation: frame ticks go in, per-cell heat items
// are checked against a cycle-free model of the cooling, drift, spark and forcing passes.
// Depends on fhs_pkg and the led_fire_heat_simulation RTL.
module led_fire_heat_simulation_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fhs_pkg::*;

  localparam int FRAME_CYCLES = 4 * MAX_CELLS + 22;
  localparam int STALL_CYCLES = 1500;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [HEAT_W-1:0]  heat;
    logic               tail;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [INDEX_W-1:0]   cell_index;
  logic [HEAT_W-1:0]    cell_heat;
  logic                 last_cell;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  cell_result_t cells_due[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  logic         rx_hold = 1'b0;
  event         stall_kick;

  logic [HEAT_W-1:0]  heat_model [MAX_CELLS];
  logic [15:0]        lfsr_model;
  logic [CELLS_W-1:0] cells_reg;
  logic [7:0]         cool_lo, cool_hi, spark_lo, spark_hi, sheat_lo, sheat_hi;
  logic [15:0]        seed_reg;

  led_fire_heat_simulation DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_index(cell_index), .cell_heat(cell_heat), .last_cell(last_cell),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_fire_heat_simulation: mismatch");
      $finish;
    end
  end

  function automatic void reset_fire_model();
    foreach (heat_model[i]) heat_model[i] = '0;
    cells_reg  = ACTIVE_CELLS_RESET;
    cool_lo    = COOLING_LOW_RESET;
    cool_hi    = COOLING_HIGH_RESET;
    spark_lo   = SPARKING_LOW_RESET;
    spark_hi   = SPARKING_HIGH_RESET;
    sheat_lo   = SPARK_HEAT_LOW_RESET;
    sheat_hi   = SPARK_HEAT_HIGH_RESET;
    seed_reg   = RANDOM_SEED_RESET;
    lfsr_model = seed_reg;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [15:0] v);
    case (idx)
      CFG_ACTIVE_CELLS:    cells_reg = v[CELLS_W-1:0];
      CFG_COOLING_LOW:     cool_lo = v[7:0];
      CFG_COOLING_HIGH:    cool_hi = v[7:0];
      CFG_SPARKING_LOW:    spark_lo = v[7:0];
      CFG_SPARKING_HIGH:   spark_hi = v[7:0];
      CFG_SPARK_HEAT_LOW:  sheat_lo = v[7:0];
      CFG_SPARK_HEAT_HIGH: sheat_hi = v[7:0];
      CFG_RANDOM_SEED: begin
        seed_reg   = v;
        lfsr_model = (v == 16'd0) ? 16'd1 : v;
      end
      default: ;
    endcase
  endfunction

  function automatic int noise_byte();
    logic [15:0] s;
    s = lfsr_model;
    for (int k = 0; k < LFSR_STEPS; k++) begin
      if (s[0]) s = (s >> 1) ^ LFSR_TAPS;
      else s = s >> 1;
    end
    lfsr_model = s;
    return int'(s[7:0]);
  endfunction

  function automatic int noise_below(int bound);
    return (noise_byte() * bound) >> 8;
  endfunction

  function automatic int level_map(logic [7:0] lvl, logic [7:0] lo, logic [7:0] hi);
    int d;
    int q;
    d = int'(hi) - int'(lo);
    q = (int'(lvl) * d) / 255;
    return (int'(lo) + q) & 255;
  endfunction

  function automatic void predict_frame(logic [7:0] lvl);
    int n, cool, chance, sheat, bound, c, y, amt, s;
    cell_result_t r;
    n = int'(cells_reg);
    if (n < MIN_CELLS) n = MIN_CELLS;
    if (n > MAX_CELLS) n = MAX_CELLS;
    cool   = level_map(lvl, cool_lo, cool_hi);
    chance = level_map(lvl, spark_lo, spark_hi);
    sheat  = level_map(lvl, sheat_lo, sheat_hi);
    bound = cool * COOL_GAIN / n + BOUND_BIAS;
    if (bound > HEAT_MAX) bound = HEAT_MAX;
    for (int i = 0; i < n; i++) begin
      c = noise_below(bound);
      heat_model[i] = (int'(heat_model[i]) > c) ? 8'(int'(heat_model[i]) - c) : 8'd0;
    end
    for (int i = n - 1; i >= DRIFT_FIRST; i--) begin
      heat_model[i] = 8'((2 * int'(heat_model[i-1]) + int'(heat_model[i-2])) / 3);
    end
    if (noise_byte() < chance) begin
      y   = noise_below(SPARK_ZONE);
      amt = (sheat + 256 - SPARK_SPAN + noise_below(SPARK_SPAN)) & 255;
      if (y < MAX_CELLS) begin
        s = int'(heat_model[y]) + amt;
        heat_model[y] = (s > HEAT_MAX) ? 8'(HEAT_MAX) : 8'(s);
      end
    end
    heat_model[0] = 8'((sheat + 256 - FORCE0_DROP) & 255);
    heat_model[1] = 8'((sheat + 256 - FORCE1_DROP) & 255);
    for (int i = 0; i < n; i++) begin
      r.index = INDEX_W'(i);
      r.heat  = heat_model[i];
      r.tail  = (i + 1 == n);
      cells_due.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        $error("unexpected item: cell_index %0d cell_heat %0d", cell_index, cell_heat);
        mismatch_count++;
      end else begin
        want = cells_due.pop_front();
        if (cell_index !== want.index) begin
          $error("cell_index: expected %0d, got %0d", want.index, cell_index);
          mismatch_count++;
        end
        if (cell_heat !== want.heat) begin
          $error("cell_heat: expected %0d, got %0d", want.heat, cell_heat);
          mismatch_count++;
        end
        if (last_cell !== want.tail) begin
          $error("last_cell: expected %0d, got %0d", want.tail, last_cell);
          mismatch_count++;
        end
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always begin
    @(stall_kick);
    rx_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    apply_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(logic [7:0] lvl);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    level    <= lvl;
    do @(posedge clk); while (!in_ready);
    predict_frame(lvl);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cells_due.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic randomize_regs();
    int pick;
    logic [15:0] v;
    pick = $urandom_range(9);
    if (pick < 6) v = 16'($urandom_range(MIN_CELLS, 16));
    else if (pick < 8) v = 16'($urandom_range(17, MAX_CELLS));
    else v = 16'($urandom_range(127));
    write_reg(CFG_ACTIVE_CELLS, (16'($urandom) & 16'hFF80) | v);
    write_reg(CFG_COOLING_LOW, 16'($urandom));
    write_reg(CFG_COOLING_HIGH, 16'($urandom));
    write_reg(CFG_SPARKING_LOW, 16'($urandom));
    write_reg(CFG_SPARKING_HIGH, 16'($urandom));
    write_reg(CFG_SPARK_HEAT_LOW, 16'($urandom));
    write_reg(CFG_SPARK_HEAT_HIGH, 16'($urandom));
    write_reg(CFG_RANDOM_SEED, ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_frame(8'd0);
    send_frame(8'd255);
    send_frame(8'd128);
    send_frame(8'($urandom));
    stop_input();
    wait_idle();
  endtask

  task automatic test_cell_count_limits();
    int counts[6] = '{0, 2, 3, 64, 127, 65};
    foreach (counts[i]) begin
      write_reg(CFG_ACTIVE_CELLS, 16'(counts[i]));
      send_frame(8'($urandom));
      stop_input();
      wait_idle();
    end
  endtask

  task automatic test_map_extremes();
    write_reg(CFG_ACTIVE_CELLS, 16'd8);
    write_reg(CFG_COOLING_LOW, 16'd255);
    write_reg(CFG_COOLING_HIGH, 16'd0);
    write_reg(CFG_SPARKING_LOW, 16'd255);
    write_reg(CFG_SPARKING_HIGH, 16'd255);
    write_reg(CFG_SPARK_HEAT_LOW, 16'd0);
    write_reg(CFG_SPARK_HEAT_HIGH, 16'd255);
    send_frame(8'd0);
    send_frame(8'd255);
    send_frame(8'd127);
    stop_input();
    wait_idle();
    // Falling spark heat, sparks disabled, and a cooling bound that saturates.
    write_reg(CFG_ACTIVE_CELLS, 16'd3);
    write_reg(CFG_COOLING_LOW, 16'd255);
    write_reg(CFG_COOLING_HIGH, 16'd255);
    write_reg(CFG_SPARKING_LOW, 16'd0);
    write_reg(CFG_SPARKING_HIGH, 16'd0);
    write_reg(CFG_SPARK_HEAT_LOW, 16'd255);
    write_reg(CFG_SPARK_HEAT_HIGH, 16'd0);
    send_frame(8'd0);
    send_frame(8'd255);
    send_frame(8'd200);
    stop_input();
    wait_idle();
  endtask

  task automatic test_seed_reload();
    write_reg(CFG_SPARKING_LOW, 16'd128);
    write_reg(CFG_SPARKING_HIGH, 16'd255);
    write_reg(CFG_RANDOM_SEED, 16'd0);
    send_frame(8'd90);
    send_frame(8'd250);
    stop_input();
    wait_idle();
    write_reg(CFG_RANDOM_SEED, 16'hFFFF);
    send_frame(8'd10);
    stop_input();
    wait_idle();
  endtask

  task automatic test_random_frames(int tx_pct, int rx_pct, int count);
    int lvl;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 10 == 0) begin
        stop_input();
        wait_idle();
        randomize_regs();
      end
      case ($urandom_range(9))
        0: lvl = 0;
        1: lvl = 255;
        default: lvl = $urandom_range(255);
      endcase
      send_frame(8'(lvl));
    end
    stop_input();
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_ACTIVE_CELLS, 16'd64);
    -> stall_kick;
    for (int i = 0; i < 5; i++) send_frame(8'($urandom));
    stop_input();
    wait_idle();
  endtask

  initial begin
    reset_fire_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_cell_count_limits();
    test_map_extremes();
    test_seed_reload();
    test_random_frames(15, 63, 32);
    test_random_frames(63, 15, 32);
    test_random_frames(0, 0, 32);
    test_output_backpressure();
    wait_idle();
    repeat (FRAME_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("led_fire_heat_simulation: match");
    end else begin
      $display("led_fire_heat_simulation: mismatch");
    end
    $finish;
  end

endmodule
